// ===== src/shifter_i2c_master_registers_defines.svh =====
// Assertion macros shared by the shifter register block.
`ifndef SHIFTER_I2C_MASTER_REGISTERS_DEFINES_SVH
`define SHIFTER_I2C_MASTER_REGISTERS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMR_ASSERT_HOLDS(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("shifter register block: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("shifter register block: assertion failed");

`endif

// ===== src/smr_pkg.sv =====
// Types and constants of the shifter I2C master register block.
package smr_pkg;

    localparam int NUM_REGS = 256;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int OFS_W    = 10;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_START_NAK = 3'd2;
    localparam logic [2:0] OP_SEND      = 3'd3;
    localparam logic [2:0] OP_RECEIVE   = 3'd4;
    localparam logic [2:0] OP_STOP      = 3'd5;

    localparam logic [OFS_W-1:0] OFS_VERID   = 10'h000;
    localparam logic [OFS_W-1:0] OFS_PARAM   = 10'h004;
    localparam logic [OFS_W-1:0] OFS_CTRL    = 10'h008;
    localparam logic [OFS_W-1:0] OFS_PIN     = 10'h00C;
    localparam logic [OFS_W-1:0] OFS_STAT    = 10'h010;
    localparam logic [OFS_W-1:0] OFS_ERR     = 10'h014;
    localparam logic [OFS_W-1:0] OFS_TIMSTAT = 10'h018;
    localparam logic [OFS_W-1:0] OFS_SIEN    = 10'h020;
    localparam logic [OFS_W-1:0] OFS_PINSTAT = 10'h050;
    localparam logic [OFS_W-1:0] OFS_RXBUF   = 10'h284;
    localparam logic [OFS_W-1:0] OFS_TXBUF   = 10'h380;

    localparam logic [IDX_W-1:0] IDX_CTRL    = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_STAT    = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_ERR     = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_TIMSTAT = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_SIEN    = IDX_W'(8);

    localparam logic [31:0] VERID_VALUE = 32'h0201_0000;
    localparam logic [31:0] PARAM_VALUE = 32'h0420_0808;
    localparam logic [31:0] PIN_VALUE   = 32'hFFFF_FFFF;
    localparam logic [31:0] STAT_RESET  = 32'h0000_0001;
    localparam logic [7:0]  DEAD_BYTE   = 8'hFF;

    localparam logic [15:0] PERIOD_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]       command;
        logic [OFS_W-1:0] register_offset;
        logic [31:0]      write_data;
        logic             slave_ack;
        logic [7:0]       slave_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        interrupt;
        logic [2:0]  bus_operation;
        logic [6:0]  bus_address;
        logic        bus_direction_read;
        logic [7:0]  bus_send_byte;
    } out_item_t;

endpackage

// ===== src/smr_channels.sv =====
// Valid/ready channel interfaces for the items and results of the block.
interface smr_in_if;
    import smr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface smr_out_if;
    import smr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/shifter_i2c_master_registers.sv =====
// Top level: register file and byte shifter of the I2C master.
//
// Usage: every transaction on the item channel is a register read, a register
// write or a time tick, and produces exactly one transaction on the result
// channel carrying the read data, the interrupt level and any bus operation.
// The user must load the shift period through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. The item is captured
// in an input register together with the registered storage read, then decoded
// in one pass into the result register. Throughput is one transaction per cycle
// while the receiver keeps ready high; the limit is the single storage read port
// used at acceptance. A finished result waiting in the result register does not
// stop the next item from entering; only when both registers are full and the
// receiver holds ready low does the item channel drop ready.
// Reset clears all control state and every storage valid bit at once, so the
// register file reads as zero with the shifter status word at 1; there is no
// clearing pass. A soft reset through CTRL clears every valid bit but CTRL's.
`include "shifter_i2c_master_registers_defines.svh"

module shifter_i2c_master_registers (
    input  logic        clk,
    input  logic        rst_n,
    smr_in_if.sink      item,
    smr_out_if.source   result,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import smr_pkg::*;

    localparam logic [NUM_REGS-1:0] VALID_AFTER_SOFT = NUM_REGS'(1) << IDX_CTRL;

    // Storage for the plain registers.
    logic [31:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] valid_next;
    logic [31:0]         mem_rdata_reg;
    logic                mem_rvalid_reg;

    logic                accept;
    logic                advance;
    logic [IDX_W-1:0]    in_idx;
    logic                mem_we;
    logic                mem_soft_reset;
    logic [31:0]         mem_wdata;

    logic                s1_valid_reg;
    in_item_t            s1_item_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;
    out_item_t           res_next;

    logic [15:0] period_reg;
    logic [15:0] period_eff;

    logic [31:0] stat_reg, stat_next;
    logic [31:0] err_reg, err_next;
    logic [31:0] timstat_reg, timstat_next;
    logic [31:0] sien_reg, sien_next;
    logic        started_reg, started_next;
    logic        dead_reg, dead_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_pending_reg, tx_pending_next;
    logic [7:0]  rx_byte_reg, rx_byte_next;
    logic        rx_full_reg, rx_full_next;
    logic [15:0] countdown_reg, countdown_next;

    logic [IDX_W-1:0] s1_idx;
    logic [31:0]      plain_rdata;
    logic [31:0]      s1_data;
    logic             close_op;

    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !s1_valid_reg || advance;
    assign accept      = item.valid && item.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // Storage writes are independent of the flag state, so they are done as
    // the item is accepted, in the same order as the items.
    assign in_idx = item.payload.register_offset[OFS_W-1:2];

    always_comb
    begin
        mem_we = accept && (item.payload.command == CMD_WRITE)
            && (item.payload.register_offset != OFS_VERID)
            && (item.payload.register_offset != OFS_PARAM)
            && (item.payload.register_offset != OFS_STAT)
            && (item.payload.register_offset != OFS_ERR)
            && (item.payload.register_offset != OFS_TIMSTAT)
            && (item.payload.register_offset != OFS_SIEN)
            && (item.payload.register_offset != OFS_TXBUF);
        mem_soft_reset = mem_we && (item.payload.register_offset == OFS_CTRL)
            && item.payload.write_data[1];
        mem_wdata = item.payload.write_data;
        if (mem_soft_reset)
        begin
            mem_wdata[1] = 1'b0;
        end
        valid_next = valid_reg;
        if (mem_soft_reset)
        begin
            valid_next = VALID_AFTER_SOFT;
        end
        else if (mem_we)
        begin
            valid_next[in_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (mem_we)
            begin
                mem[in_idx] <= mem_wdata;
            end
            mem_rdata_reg  <= mem[in_idx];
            mem_rvalid_reg <= valid_reg[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Input register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item.payload;
        end
        if (advance)
        begin
            out_item_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            period_reg <= cfg_wdata;
        end
    end

    assign period_eff = (period_reg == '0) ? 16'd1 : period_reg;
    assign s1_idx     = s1_item_reg.register_offset[OFS_W-1:2];
    assign s1_data    = s1_item_reg.write_data;
    assign close_op   = started_reg && !dead_reg;

    // The status, error, timer status and enable words live in flip-flops.
    always_comb
    begin
        unique case (s1_idx)
            IDX_STAT:    plain_rdata = stat_reg;
            IDX_ERR:     plain_rdata = err_reg;
            IDX_TIMSTAT: plain_rdata = timstat_reg;
            IDX_SIEN:    plain_rdata = sien_reg;
            default:     plain_rdata = mem_rvalid_reg ? mem_rdata_reg : '0;
        endcase
    end

    always_comb
    begin : decode
        logic shift_ack;

        shift_ack       = 1'b0;
        stat_next       = stat_reg;
        err_next        = err_reg;
        timstat_next    = timstat_reg;
        sien_next       = sien_reg;
        started_next    = started_reg;
        dead_next       = dead_reg;
        is_read_next    = is_read_reg;
        tx_byte_next    = tx_byte_reg;
        tx_pending_next = tx_pending_reg;
        rx_byte_next    = rx_byte_reg;
        rx_full_next    = rx_full_reg;
        countdown_next  = countdown_reg;
        res_next        = '0;

        if (advance)
        begin
            unique case (s1_item_reg.command)
                CMD_READ:
                begin
                    priority if (s1_item_reg.register_offset == OFS_VERID)
                    begin
                        res_next.read_data = VERID_VALUE;
                    end
                    else if (s1_item_reg.register_offset == OFS_PARAM)
                    begin
                        res_next.read_data = PARAM_VALUE;
                    end
                    else if (s1_item_reg.register_offset == OFS_PIN
                        || s1_item_reg.register_offset == OFS_PINSTAT)
                    begin
                        res_next.read_data = PIN_VALUE;
                    end
                    else if (s1_item_reg.register_offset == OFS_RXBUF)
                    begin
                        res_next.read_data = {24'b0, rx_byte_reg};
                        rx_full_next       = 1'b0;
                        stat_next[1]       = 1'b0;
                    end
                    else
                    begin
                        res_next.read_data = plain_rdata;
                    end
                end
                CMD_WRITE:
                begin
                    priority if (s1_item_reg.register_offset == OFS_VERID
                        || s1_item_reg.register_offset == OFS_PARAM)
                    begin
                        res_next.bus_operation = OP_NONE;
                    end
                    else if (s1_item_reg.register_offset == OFS_STAT)
                    begin
                        stat_next = stat_reg & ~s1_data;
                    end
                    else if (s1_item_reg.register_offset == OFS_ERR)
                    begin
                        err_next = err_reg & ~s1_data;
                    end
                    else if (s1_item_reg.register_offset == OFS_TIMSTAT)
                    begin
                        timstat_next = timstat_reg & ~s1_data;
                    end
                    else if (s1_item_reg.register_offset == OFS_SIEN)
                    begin
                        sien_next = s1_data;
                        if ((|s1_data[1:0]) || (|sien_reg[1:0]))
                        begin
                            res_next.bus_operation = close_op ? OP_STOP : OP_NONE;
                            started_next    = 1'b0;
                            dead_next       = 1'b0;
                            tx_pending_next = 1'b0;
                            rx_full_next    = 1'b0;
                            countdown_next  = '0;
                            stat_next       = STAT_RESET;
                            // Disabling the shifter also flags the timer.
                            if (s1_data[1:0] == 2'b00)
                            begin
                                timstat_next[0] = 1'b1;
                            end
                        end
                    end
                    else if (s1_item_reg.register_offset == OFS_TXBUF)
                    begin
                        if (|sien_reg[1:0])
                        begin
                            tx_byte_next    = s1_data[7:0];
                            tx_pending_next = 1'b1;
                            stat_next[0]    = 1'b0;
                            countdown_next  = period_eff;
                        end
                    end
                    else
                    begin
                        if (s1_item_reg.register_offset == OFS_CTRL && s1_data[1])
                        begin
                            res_next.bus_operation = close_op ? OP_STOP : OP_NONE;
                            started_next    = 1'b0;
                            dead_next       = 1'b0;
                            countdown_next  = '0;
                            tx_pending_next = 1'b0;
                            rx_full_next    = 1'b0;
                            stat_next       = STAT_RESET;
                            err_next        = '0;
                            timstat_next    = '0;
                            sien_next       = '0;
                        end
                        // Unaligned offsets may land on the flip-flop words.
                        unique case (s1_idx)
                            IDX_STAT:    stat_next    = s1_data;
                            IDX_ERR:     err_next     = s1_data;
                            IDX_TIMSTAT: timstat_next = s1_data;
                            IDX_SIEN:    sien_next    = s1_data;
                            default:     ;
                        endcase
                    end
                end
                CMD_TICK:
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - 16'd1;
                        if (countdown_reg == 16'd1 && tx_pending_reg)
                        begin
                            if (rx_full_reg)
                            begin
                                countdown_next = period_eff;
                            end
                            else
                            begin
                                tx_pending_next = 1'b0;
                                priority if (!started_reg)
                                begin
                                    is_read_next = tx_byte_reg[0];
                                    started_next = 1'b1;
                                    rx_byte_next = '0;
                                    dead_next    = !s1_item_reg.slave_ack;
                                    shift_ack    = s1_item_reg.slave_ack;
                                    res_next.bus_operation = s1_item_reg.slave_ack
                                        ? OP_START : OP_START_NAK;
                                    res_next.bus_address        = tx_byte_reg[7:1];
                                    res_next.bus_direction_read = tx_byte_reg[0];
                                end
                                else if (dead_reg)
                                begin
                                    rx_byte_next = DEAD_BYTE;
                                    shift_ack    = 1'b0;
                                end
                                else if (is_read_reg)
                                begin
                                    rx_byte_next = s1_item_reg.slave_data;
                                    shift_ack    = 1'b1;
                                    res_next.bus_operation = OP_RECEIVE;
                                end
                                else
                                begin
                                    rx_byte_next = '0;
                                    shift_ack    = s1_item_reg.slave_ack;
                                    res_next.bus_operation = OP_SEND;
                                    res_next.bus_send_byte = tx_byte_reg;
                                end
                                rx_full_next   = 1'b1;
                                stat_next[1:0] = 2'b11;
                                err_next[1]    = !shift_ack;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        res_next.interrupt = |(stat_next[1:0] & sien_next[1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg       <= STAT_RESET;
            err_reg        <= '0;
            timstat_reg    <= '0;
            sien_reg       <= '0;
            started_reg    <= 1'b0;
            dead_reg       <= 1'b0;
            is_read_reg    <= 1'b0;
            tx_byte_reg    <= '0;
            tx_pending_reg <= 1'b0;
            rx_byte_reg    <= '0;
            rx_full_reg    <= 1'b0;
            countdown_reg  <= '0;
        end
        else
        begin
            stat_reg       <= stat_next;
            err_reg        <= err_next;
            timstat_reg    <= timstat_next;
            sien_reg       <= sien_next;
            started_reg    <= started_next;
            dead_reg       <= dead_next;
            is_read_reg    <= is_read_next;
            tx_byte_reg    <= tx_byte_next;
            tx_pending_reg <= tx_pending_next;
            rx_byte_reg    <= rx_byte_next;
            rx_full_reg    <= rx_full_next;
            countdown_reg  <= countdown_next;
        end
    end

    `SMR_ASSERT_NEXT(a_irq_tracks_state, clk, rst_n, advance,
        out_item_reg.interrupt == (|(stat_reg[1:0] & sien_reg[1:0])))
    `SMR_ASSERT_HOLDS(a_dead_needs_start, clk, rst_n, dead_reg, started_reg)
    `SMR_ASSERT_HOLDS(a_armed_needs_pending, clk, rst_n, countdown_reg != '0, tx_pending_reg)
    `SMR_ASSERT_NEXT(a_soft_reset_clears_file, clk, rst_n, mem_soft_reset,
        valid_reg == VALID_AFTER_SOFT)

endmodule

// ===== tb/sv/shifter_i2c_master_registers_test.sv =====
// Self-checking testbench for the shifter I2C master register block.
`timescale 1ns / 100ps

module shifter_i2c_master_registers_test;
    import smr_pkg::*;

    localparam logic [1:0]  CMD_IGNORED    = 2'd3;
    localparam logic [31:0] IRQ_ENABLES    = 32'h0000_0003;
    localparam logic [31:0] SOFT_RESET_BIT = 32'h0000_0002;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRINT_LIMIT     = 40;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int N_PHASES        = 7;
    localparam logic [15:0] PHASE_PERIODS [N_PHASES] =
        '{16'd1, 16'd65535, 16'd2, 16'd0, 16'd3, 16'd17, 16'd1};
    localparam logic [OFS_W-1:0] HOT_OFFSETS [11] =
        '{OFS_VERID, OFS_PARAM, OFS_CTRL, OFS_PIN, OFS_STAT, OFS_ERR,
          OFS_TIMSTAT, OFS_SIEN, OFS_PINSTAT, OFS_RXBUF, OFS_TXBUF};

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_PERIOD} row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [1:0]       cmd;
        logic [OFS_W-1:0] ofs;
        logic [31:0]      data;
        logic             ack;
        logic [7:0]       sdata;
        logic [31:0]      want_data;
        logic             want_irq;
    } script_row_t;

    localparam int N_SCRIPT = 35;
    localparam script_row_t SCRIPT [N_SCRIPT] = '{
        '{ROW_TYPED,   CMD_READ,    OFS_VERID,   32'h0,         1'b0, 8'h00, VERID_VALUE, 1'b0},
        '{ROW_TYPED,   CMD_READ,    OFS_PARAM,   32'h0,         1'b0, 8'h00, PARAM_VALUE, 1'b0},
        '{ROW_TYPED,   CMD_READ,    OFS_PINSTAT, 32'h0,         1'b0, 8'h00, PIN_VALUE,   1'b0},
        '{ROW_TYPED,   CMD_READ,    OFS_STAT,    32'h0,         1'b0, 8'h00, STAT_RESET,  1'b0},
        '{ROW_TYPED,   CMD_WRITE,   OFS_PARAM,   32'hFFFF_FFFF, 1'b1, 8'hFF, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0000_0055, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_TYPED,   CMD_IGNORED, 10'h3FF,     32'hFFFF_FFFF, 1'b1, 8'hFF, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   10'h3FF,     32'hA5A5_A5A5, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_READ,    10'h3FD,     32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_CTRL,    32'hFFFF_FFFF, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PERIOD,  CMD_READ,    OFS_VERID,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_SIEN,    32'h0000_0003, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0000_00A0, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b1, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0000_003C, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b1, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_READ,    OFS_RXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_SIEN,    32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_SIEN,    32'h0000_0002, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0000_00FF, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_READ,    OFS_RXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b1, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_READ,    OFS_RXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_CTRL,    32'h0000_0002, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_SIEN,    32'h0000_0001, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0000_0001, 1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b1, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_READ,    OFS_RXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_TXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_TICK,    OFS_VERID,   32'h0,         1'b1, 8'h5A, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_READ,    OFS_RXBUF,   32'h0,         1'b0, 8'h00, 32'h0,       1'b0},
        '{ROW_PREDICT, CMD_WRITE,   OFS_CTRL,    32'h0000_0002, 1'b0, 8'h00, 32'h0,       1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    smr_in_if  item_bus ();
    smr_out_if result_bus ();

    shifter_i2c_master_registers dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Shadow of the block state used by the predictor.
    logic [31:0] mirror_regs [NUM_REGS];
    logic        xfer_started;
    logic        xfer_dead;
    logic        xfer_read;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic        tx_pending;
    logic        rx_full;
    logic [15:0] countdown;
    logic [15:0] shift_period;

    out_item_t replies_due [$];
    int        fail_count   = 0;
    int        items_sent   = 0;
    int        gap_pct      = 0;
    int        stall_pct    = 0;
    int        quiet_cycles = 0;

    function automatic logic [15:0] effective_period();
        return (shift_period == 16'd0) ? 16'd1 : shift_period;
    endfunction

    function automatic logic [2:0] end_transfer();
        logic [2:0] op;
        op = (xfer_started && !xfer_dead) ? OP_STOP : OP_NONE;
        xfer_started = 1'b0;
        xfer_dead    = 1'b0;
        return op;
    endfunction

    function automatic void wipe_registers();
        for (int i = 0; i < NUM_REGS; i++)
            mirror_regs[i] = '0;
        mirror_regs[IDX_STAT] = STAT_RESET;
    endfunction

    function automatic out_item_t predict_register_access(in_item_t it);
        out_item_t        r;
        logic [IDX_W-1:0] idx;
        logic [31:0]      v;
        logic [31:0]      prev_sien;
        logic             ack;
        r   = '0;
        idx = it.register_offset[OFS_W-1:2];
        v   = it.write_data;
        case (it.command)
            CMD_READ:
            begin
                if (it.register_offset == OFS_VERID)
                    r.read_data = VERID_VALUE;
                else if (it.register_offset == OFS_PARAM)
                    r.read_data = PARAM_VALUE;
                else if (it.register_offset == OFS_PIN || it.register_offset == OFS_PINSTAT)
                    r.read_data = PIN_VALUE;
                else if (it.register_offset == OFS_RXBUF)
                begin
                    rx_full = 1'b0;
                    mirror_regs[IDX_STAT][1] = 1'b0;
                    r.read_data = {24'h0, rx_byte};
                end
                else
                    r.read_data = mirror_regs[idx];
            end
            CMD_WRITE:
            begin
                if (it.register_offset == OFS_VERID || it.register_offset == OFS_PARAM)
                    r.bus_operation = OP_NONE;
                else if (it.register_offset == OFS_STAT || it.register_offset == OFS_ERR
                         || it.register_offset == OFS_TIMSTAT)
                    mirror_regs[idx] = mirror_regs[idx] & ~v;
                else if (it.register_offset == OFS_SIEN)
                begin
                    prev_sien = mirror_regs[IDX_SIEN];
                    mirror_regs[IDX_SIEN] = v;
                    if ((v & IRQ_ENABLES) != 0 || (prev_sien & IRQ_ENABLES) != 0)
                    begin
                        r.bus_operation = end_transfer();
                        tx_pending = 1'b0;
                        rx_full    = 1'b0;
                        countdown  = 16'd0;
                        mirror_regs[IDX_STAT] = STAT_RESET;
                        if ((v & IRQ_ENABLES) == 0)
                            mirror_regs[IDX_TIMSTAT][0] = 1'b1;
                    end
                end
                else if (it.register_offset == OFS_TXBUF)
                begin
                    if ((mirror_regs[IDX_SIEN] & IRQ_ENABLES) != 0)
                    begin
                        tx_byte    = v[7:0];
                        tx_pending = 1'b1;
                        mirror_regs[IDX_STAT][0] = 1'b0;
                        countdown  = effective_period();
                    end
                end
                else
                begin
                    if (it.register_offset == OFS_CTRL && (v & SOFT_RESET_BIT) != 0)
                    begin
                        r.bus_operation = end_transfer();
                        countdown  = 16'd0;
                        wipe_registers();
                        tx_pending = 1'b0;
                        rx_full    = 1'b0;
                        v = v & ~SOFT_RESET_BIT;
                    end
                    mirror_regs[idx] = v;
                end
            end
            CMD_TICK:
            begin
                if (countdown != 16'd0)
                begin
                    countdown = countdown - 16'd1;
                    if (countdown == 16'd0 && tx_pending)
                    begin
                        // An unread receive byte holds the shift back for another period.
                        if (rx_full)
                            countdown = effective_period();
                        else
                        begin
                            tx_pending = 1'b0;
                            if (!xfer_started)
                            begin
                                xfer_read    = tx_byte[0];
                                ack          = it.slave_ack;
                                xfer_started = 1'b1;
                                rx_byte      = 8'h00;
                                xfer_dead    = !ack;
                                r.bus_operation      = ack ? OP_START : OP_START_NAK;
                                r.bus_address        = tx_byte[7:1];
                                r.bus_direction_read = xfer_read;
                            end
                            else if (xfer_dead)
                            begin
                                rx_byte = DEAD_BYTE;
                                ack     = 1'b0;
                            end
                            else if (xfer_read)
                            begin
                                rx_byte = it.slave_data;
                                ack     = 1'b1;
                                r.bus_operation = OP_RECEIVE;
                            end
                            else
                            begin
                                ack     = it.slave_ack;
                                rx_byte = 8'h00;
                                r.bus_operation = OP_SEND;
                                r.bus_send_byte = tx_byte;
                            end
                            rx_full = 1'b1;
                            mirror_regs[IDX_STAT] = mirror_regs[IDX_STAT] | IRQ_ENABLES;
                            mirror_regs[IDX_ERR][1] = !ack;
                        end
                    end
                end
            end
            default:
                r.bus_operation = OP_NONE;
        endcase
        r.interrupt = |(mirror_regs[IDX_STAT][1:0] & mirror_regs[IDX_SIEN][1:0]);
        return r;
    endfunction

    function automatic in_item_t build_item(logic [1:0] cmd, logic [OFS_W-1:0] ofs,
                                            logic [31:0] data, logic ack, logic [7:0] sdata);
        in_item_t it;
        it.command         = cmd;
        it.register_offset = ofs;
        it.write_data      = data;
        it.slave_ack       = ack;
        it.slave_data      = sdata;
        return it;
    endfunction

    function automatic logic [OFS_W-1:0] any_offset();
        return OFS_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                             input out_item_t typed_reply = '0);
        out_item_t predicted;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        predicted = predict_register_access(it);
        replies_due.push_back(typed ? typed_reply : predicted);
        items_sent++;
    endtask

    // The period is only changed once every outstanding transaction has returned.
    task automatic load_period(input logic [15:0] value);
        item_bus.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shift_period = value;
    endtask

    task automatic run_noise(input int count);
        logic [OFS_W-1:0] ofs;
        repeat (count)
        begin
            ofs = ($urandom_range(0, 1) == 0) ? HOT_OFFSETS[$urandom_range(0, 10)]
                                              : any_offset();
            send_item(build_item(2'($urandom_range(0, 3)), ofs, $urandom(),
                                 1'($urandom_range(0, 1)), any_byte()));
        end
    endtask

    // Enable the shifter, move a few bytes, then close the transfer in one of several ways or leave it open.
    task automatic run_transfer();
        logic [31:0] sien;
        int          n_ticks;
        sien = $urandom();
        if ((sien & IRQ_ENABLES) == 0)
            sien = sien | 32'h1;
        send_item(build_item(CMD_WRITE, OFS_SIEN, sien, 1'($urandom_range(0, 1)), any_byte()));
        repeat ($urandom_range(1, 6))
        begin
            send_item(build_item(CMD_WRITE, OFS_TXBUF, $urandom(), 1'($urandom_range(0, 1)),
                                 any_byte()));
            n_ticks = (effective_period() > 16'd40) ? 40 : int'(effective_period());
            n_ticks += $urandom_range(0, 2);
            if (n_ticks > 0 && $urandom_range(0, 9) == 0)
                n_ticks--;
            repeat (n_ticks)
                send_item(build_item(CMD_TICK, any_offset(), $urandom(),
                                     $urandom_range(0, 99) < 85, any_byte()));
            if ($urandom_range(0, 3) != 0)
                send_item(build_item(CMD_READ, OFS_RXBUF, $urandom(), 1'($urandom_range(0, 1)),
                                     any_byte()));
            if ($urandom_range(0, 7) == 0)
                run_noise(1);
        end
        case ($urandom_range(0, 3))
            0: send_item(build_item(CMD_WRITE, OFS_SIEN, $urandom() & ~IRQ_ENABLES, 1'b0,
                                    any_byte()));
            1: send_item(build_item(CMD_WRITE, OFS_CTRL, $urandom() | SOFT_RESET_BIT, 1'b1,
                                    any_byte()));
            2: send_item(build_item(CMD_WRITE, OFS_SIEN, $urandom() | 32'h1, 1'b0, any_byte()));
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        int hold;
        hold = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                result_bus.ready <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(0, 5);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = result_bus.payload;
            if (replies_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= PRINT_LIMIT)
                    $display("%0t: unrequested result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("interrupt", 32'(want.interrupt), 32'(got.interrupt));
                check_field("bus_operation", 32'(want.bus_operation),
                            32'(got.bus_operation));
                check_field("bus_address", 32'(want.bus_address), 32'(got.bus_address));
                check_field("bus_direction_read", 32'(want.bus_direction_read),
                            32'(got.bus_direction_read));
                check_field("bus_send_byte", 32'(want.bus_send_byte),
                            32'(got.bus_send_byte));
            end
        end
    end

    // Stop the run if neither channel completes a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_start;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        item_bus.valid   <= 1'b0;
        item_bus.payload <= '0;
        wipe_registers();
        xfer_started = 1'b0;
        xfer_dead    = 1'b0;
        xfer_read    = 1'b0;
        tx_byte      = 8'h00;
        tx_pending   = 1'b0;
        rx_byte      = 8'h00;
        rx_full      = 1'b0;
        countdown    = 16'd0;
        shift_period = PERIOD_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == ROW_PERIOD)
                load_period(SCRIPT[i].data[15:0]);
            else
                send_item(build_item(SCRIPT[i].cmd, SCRIPT[i].ofs, SCRIPT[i].data,
                                     SCRIPT[i].ack, SCRIPT[i].sdata),
                          SCRIPT[i].kind == ROW_TYPED,
                          '{read_data: SCRIPT[i].want_data, interrupt: SCRIPT[i].want_irq,
                            bus_operation: OP_NONE, default: '0});
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            load_period(PHASE_PERIODS[phase]);
            // The third phase and the last one run without any idle cycles.
            if (phase == 2 || phase == N_PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(5, 35);
                stall_pct = $urandom_range(5, 35);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                    run_transfer();
                else
                    run_noise($urandom_range(3, 10));
            end
        end

        item_bus.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
